// ===== design/tcp_pkg.sv =====
// Shared types and constants for the token challenge parser.
`timescale 1ns / 1ps

package tcp_pkg;

  // Parser position within one challenge message.
  typedef enum logic [3:0] {
    PH_TYPE_HI   = 4'd0,
    PH_TYPE_LO   = 4'd1,
    PH_ISSLEN_HI = 4'd2,
    PH_ISSLEN_LO = 4'd3,
    PH_ISSUER    = 4'd4,
    PH_CTXLEN    = 4'd5,
    PH_CTX       = 4'd6,
    PH_ORGLEN_HI = 4'd7,
    PH_ORGLEN_LO = 4'd8,
    PH_ORIGIN    = 4'd9,
    PH_DONE      = 4'd10,
    PH_ERROR     = 4'd11
  } phase_e;

  // Field tag attached to every byte.
  typedef enum logic [3:0] {
    FC_TYPE    = 4'd0,
    FC_ISSLEN  = 4'd1,
    FC_ISSUER  = 4'd2,
    FC_CTXLEN  = 4'd3,
    FC_CTX     = 4'd4,
    FC_ORGLEN  = 4'd5,
    FC_ORIGIN  = 4'd6,
    FC_COMMA   = 4'd7,
    FC_IGNORED = 4'd8
  } field_e;

  // Message status reported on the last beat.
  typedef enum logic [2:0] {
    ST_RUN      = 3'd0,
    ST_OK       = 3'd1,
    ST_EARLY    = 3'd2,
    ST_BADCTX   = 3'd3,
    ST_TRAILING = 3'd4
  } status_e;

  localparam logic [7:0] COMMA_CHAR = 8'h2C;

endpackage

// ===== design/token_challenge_parser.sv =====
// Byte-serial parser for a length-prefixed token challenge.
// Each accepted input beat is registered as its result beat in the output register.
// Throughput: one byte per cycle; a new beat is taken whenever the output register is empty
// or is being drained in the same cycle, so the single output register sets the rate.
// Reset: rst_ni clears the parse state and the output valid flag asynchronously; the parser
// also returns to its reset state after every beat marked last.
`timescale 1ns / 1ps

module token_challenge_parser #(
  parameter int unsigned CONTEXT_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  byte_out_o,
  output logic [3:0]  field_code_o,
  output logic [15:0] origin_item_o,
  output logic [15:0] type_value_o,
  output logic [2:0]  message_status_o,
  output logic        message_end_o
);

  localparam logic [7:0] CtxLen = 8'(CONTEXT_BYTES);

  // Parse state.
  tcp_pkg::phase_e  phase_q, phase_d, phase_step;
  logic [15:0]      bytes_left_q, bytes_left_d, bytes_left_step;
  logic [7:0]       length_high_q, length_high_d, length_high_step;
  logic [15:0]      type_q, type_d, type_step;
  logic [15:0]      item_q, item_d, item_step;
  tcp_pkg::status_e err_q, err_d, err_step;

  // Result of the current beat.
  tcp_pkg::field_e  code;
  logic [15:0]      item_out;
  tcp_pkg::status_e status;

  // Output register.
  logic             out_valid_q;
  logic [7:0]       byte_q;
  tcp_pkg::field_e  code_q;
  logic [15:0]      item_out_q;
  logic [15:0]      type_out_q;
  tcp_pkg::status_e status_q;
  logic             end_q;

  logic             in_accept;
  logic [15:0]      len16;
  logic [15:0]      left_dec;

  // The output register frees itself in the same cycle it is drained, so the
  // input side keeps streaming while the consumer keeps up.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  assign len16    = {length_high_q, data_byte_i};
  assign left_dec = bytes_left_q - 16'd1;

  // Next-state logic: advance through the message by one byte.
  always_comb begin
    phase_step       = phase_q;
    bytes_left_step  = bytes_left_q;
    length_high_step = length_high_q;
    type_step        = type_q;
    item_step        = item_q;
    err_step         = err_q;
    case (phase_q)
      tcp_pkg::PH_TYPE_HI: begin
        length_high_step = data_byte_i;
        phase_step       = tcp_pkg::PH_TYPE_LO;
      end
      tcp_pkg::PH_TYPE_LO: begin
        type_step  = len16;
        phase_step = tcp_pkg::PH_ISSLEN_HI;
      end
      tcp_pkg::PH_ISSLEN_HI: begin
        length_high_step = data_byte_i;
        phase_step       = tcp_pkg::PH_ISSLEN_LO;
      end
      tcp_pkg::PH_ISSLEN_LO: begin
        bytes_left_step = len16;
        phase_step = (len16 == 16'd0) ? tcp_pkg::PH_CTXLEN : tcp_pkg::PH_ISSUER;
      end
      tcp_pkg::PH_ISSUER: begin
        bytes_left_step = left_dec;
        if (left_dec == 16'd0) begin
          phase_step = tcp_pkg::PH_CTXLEN;
        end
      end
      tcp_pkg::PH_CTXLEN: begin
        if (data_byte_i == 8'd0) begin
          phase_step = tcp_pkg::PH_ORGLEN_HI;
        end else if (data_byte_i == CtxLen) begin
          bytes_left_step = {8'd0, data_byte_i};
          phase_step      = tcp_pkg::PH_CTX;
        end else begin
          err_step   = tcp_pkg::ST_BADCTX;
          phase_step = tcp_pkg::PH_ERROR;
        end
      end
      tcp_pkg::PH_CTX: begin
        bytes_left_step = left_dec;
        if (left_dec == 16'd0) begin
          phase_step = tcp_pkg::PH_ORGLEN_HI;
        end
      end
      tcp_pkg::PH_ORGLEN_HI: begin
        length_high_step = data_byte_i;
        phase_step       = tcp_pkg::PH_ORGLEN_LO;
      end
      tcp_pkg::PH_ORGLEN_LO: begin
        bytes_left_step = len16;
        item_step       = 16'd0;
        phase_step = (len16 == 16'd0) ? tcp_pkg::PH_DONE : tcp_pkg::PH_ORIGIN;
      end
      tcp_pkg::PH_ORIGIN: begin
        if (data_byte_i == tcp_pkg::COMMA_CHAR) begin
          item_step = item_q + 16'd1;
        end
        bytes_left_step = left_dec;
        if (left_dec == 16'd0) begin
          phase_step = tcp_pkg::PH_DONE;
        end
      end
      tcp_pkg::PH_DONE: begin
        // Anything after a complete message is trailing data.
        err_step   = tcp_pkg::ST_TRAILING;
        phase_step = tcp_pkg::PH_ERROR;
      end
      default: begin
        phase_step = tcp_pkg::PH_ERROR;
      end
    endcase

    // The last beat of a message puts the parser back in its reset state.
    if (last_byte_i) begin
      phase_d       = tcp_pkg::PH_TYPE_HI;
      bytes_left_d  = 16'd0;
      length_high_d = 8'd0;
      type_d        = 16'd0;
      item_d        = 16'd0;
      err_d         = tcp_pkg::ST_RUN;
    end else begin
      phase_d       = phase_step;
      bytes_left_d  = bytes_left_step;
      length_high_d = length_high_step;
      type_d        = type_step;
      item_d        = item_step;
      err_d         = err_step;
    end
  end

  // Output logic: field tag, origin item and end status of the current beat.
  always_comb begin
    code     = tcp_pkg::FC_IGNORED;
    item_out = 16'd0;
    case (phase_q)
      tcp_pkg::PH_TYPE_HI,
      tcp_pkg::PH_TYPE_LO:   code = tcp_pkg::FC_TYPE;
      tcp_pkg::PH_ISSLEN_HI,
      tcp_pkg::PH_ISSLEN_LO: code = tcp_pkg::FC_ISSLEN;
      tcp_pkg::PH_ISSUER:    code = tcp_pkg::FC_ISSUER;
      tcp_pkg::PH_CTXLEN:    code = tcp_pkg::FC_CTXLEN;
      tcp_pkg::PH_CTX:       code = tcp_pkg::FC_CTX;
      tcp_pkg::PH_ORGLEN_HI,
      tcp_pkg::PH_ORGLEN_LO: code = tcp_pkg::FC_ORGLEN;
      tcp_pkg::PH_ORIGIN: begin
        // A comma carries the index of the item it closes.
        item_out = item_q;
        code = (data_byte_i == tcp_pkg::COMMA_CHAR) ? tcp_pkg::FC_COMMA
                                                    : tcp_pkg::FC_ORIGIN;
      end
      default: code = tcp_pkg::FC_IGNORED;
    endcase

    // The status looks at the phase after this byte, so an error raised by
    // the last byte itself is reported; the first error latched wins.
    status = tcp_pkg::ST_RUN;
    if (last_byte_i) begin
      if (phase_step == tcp_pkg::PH_ERROR) begin
        status = err_step;
      end else if (phase_step == tcp_pkg::PH_DONE) begin
        status = tcp_pkg::ST_OK;
      end else begin
        status = tcp_pkg::ST_EARLY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= tcp_pkg::PH_TYPE_HI;
      bytes_left_q  <= 16'd0;
      length_high_q <= 8'd0;
      type_q        <= 16'd0;
      item_q        <= 16'd0;
      err_q         <= tcp_pkg::ST_RUN;
    end else if (in_accept) begin
      phase_q       <= phase_d;
      bytes_left_q  <= bytes_left_d;
      length_high_q <= length_high_d;
      type_q        <= type_d;
      item_q        <= item_d;
      err_q         <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; the type shown is the value after this byte.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q     <= data_byte_i;
      code_q     <= code;
      item_out_q <= item_out;
      type_out_q <= type_step;
      status_q   <= status;
      end_q      <= last_byte_i;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign byte_out_o       = byte_q;
  assign field_code_o     = code_q;
  assign origin_item_o    = item_out_q;
  assign type_value_o     = type_out_q;
  assign message_status_o = status_q;
  assign message_end_o    = end_q;

  // A beat marked last always leaves the parser ready for a new message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && last_byte_i |=> phase_q == tcp_pkg::PH_TYPE_HI && err_q == tcp_pkg::ST_RUN)
    else $error("parser not reset after last beat");

  // A final status only appears on the result that ends a message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (message_status_o != tcp_pkg::ST_RUN) |-> message_end_o)
    else $error("status reported on a beat that is not last");

  // The error phase always holds one of the two latched error codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tcp_pkg::PH_ERROR |->
      (err_q == tcp_pkg::ST_BADCTX || err_q == tcp_pkg::ST_TRAILING))
    else $error("error phase without a latched error code");

  // Only origin bytes and commas carry a nonzero item index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (origin_item_o != 16'd0) |->
      (field_code_o == tcp_pkg::FC_ORIGIN || field_code_o == tcp_pkg::FC_COMMA))
    else $error("item index on a byte outside the origin field");

endmodule
